/* sv/kdpq_pkg.sv */
// Shared constants, codes and types for the keyed double-ended priority queue.
package kdpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COST_W  = 16;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 80;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DROP   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_SHF  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;     // compare phase: latch match and less-than flags
    logic shf;     // shift phase: move entries
    logic ins;     // place the new entry
    logic m_lt;    // removed entry sits below the insertion point
    logic rem;     // close the gap at and above rem_pos
    logic pre_en;  // rem_pos is meaningful
    logic vin;     // occupancy grows by one
    logic vout;    // occupancy shrinks by one
  } cmd_t;

endpackage

/* sv/kdpq_cell.sv */
// One cell of the sorted shift chain: holds one entry and trades it with its neighbors.
module kdpq_cell #(
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kdpq_pkg::cmd_t             cmd,
  input  logic [IW-1:0]              rem_pos,
  input  logic [kdpq_pkg::KEY_W-1:0]  in_key,
  input  logic [kdpq_pkg::COST_W-1:0] in_cost,
  input  logic [kdpq_pkg::KEY_W-1:0]  left_key,
  input  logic [kdpq_pkg::COST_W-1:0] left_cost,
  input  logic                       left_valid,
  input  logic                       left_lt,
  input  logic                       left_pre,
  input  logic [kdpq_pkg::KEY_W-1:0]  right_key,
  input  logic [kdpq_pkg::COST_W-1:0] right_cost,
  input  logic                       right_valid,
  input  logic                       right_lt,
  output logic [kdpq_pkg::KEY_W-1:0]  key,
  output logic [kdpq_pkg::COST_W-1:0] cost,
  output logic                       valid,
  output logic                       lt,
  output logic                       match,
  output logic                       pre
);
  import kdpq_pkg::*;

  logic take_l;
  logic take_r;
  logic put_new;

  // Gap at or below this cell.
  assign pre = cmd.pre_en && (rem_pos <= IW'(INDEX));

  always_comb begin
    take_l  = 1'b0;
    take_r  = 1'b0;
    put_new = 1'b0;
    if (cmd.shf) begin
      if (cmd.ins) begin
        if (cmd.m_lt) begin
          // gap below the insertion point: close it upward, new entry at L-1
          if (pre && right_lt) begin
            take_r = 1'b1;
          end else if (lt && !right_lt) begin
            put_new = 1'b1;
          end
        end else begin
          // new entry at L, entries from L up to the gap move up
          if (!lt && left_lt) begin
            put_new = 1'b1;
          end else if (!left_lt && !left_pre) begin
            take_l = 1'b1;
          end
        end
      end else if (cmd.rem) begin
        take_r = pre;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_new) begin
      key  <= in_key;
      cost <= in_cost;
    end else if (take_l) begin
      key  <= left_key;
      cost <= left_cost;
    end else if (take_r) begin
      key  <= right_key;
      cost <= right_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      match <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        match <= valid && (key == in_key);
        lt    <= valid && (cost < in_cost);
      end
      if (cmd.shf) begin
        if (cmd.vin) begin
          valid <= valid | left_valid;
        end else if (cmd.vout) begin
          valid <= right_valid;
        end
      end
    end
  end

endmodule

/* sv/keyed_double_ended_priority_queue.sv */
// Top level: chain of sorted entry cells with the sequencing control and word ports.
// Steps per word: accept, compare across the chain, shift, then the result word is registered
// once the output register is free; a new word is accepted only after that (s_tready in idle only).
// The compare and shift steps each act in every cell of the chain at once.
// Reset (rst, synchronous) empties the store: all cells invalid, count zero.
// Cell contents are not cleared; only occupied cells are ever read.
module keyed_double_ended_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // action[2:0], key[34:3], cost[50:35], zero fill
  input  logic [kdpq_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], out_key[33:2], out_cost[49:34], count[56:50], highest_cost[72:57], zero fill
  output logic [kdpq_pkg::OUT_W-1:0]  m_tdata
);
  import kdpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state;
  state_t state_next;

  logic [ACT_W-1:0]  act_q;
  logic [KEY_W-1:0]  key_q;
  logic [COST_W-1:0] cost_q;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [STAT_W-1:0] res_status;
  logic [KEY_W-1:0]  res_key;
  logic [COST_W-1:0] res_cost;
  logic [STAT_W-1:0] res_status_next;
  logic [KEY_W-1:0]  res_key_next;
  logic [COST_W-1:0] res_cost_next;

  cmd_t          cmd;
  logic [IW-1:0] rem_pos;

  logic [KEY_W-1:0]  cell_key  [CAPACITY];
  logic [COST_W-1:0] cell_cost [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] pre_vec;
  logic [CAPACITY-1:0] last_vec;
  logic [CAPACITY-1:0] sel_vec;

  logic              found;
  logic              found_lt;
  logic [IW-1:0]     match_pos;
  logic [KEY_W-1:0]  sel_key;
  logic [COST_W-1:0] sel_cost;
  logic [COST_W-1:0] highest;
  logic              accept;
  logic              out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // ---- cell chain ----
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KEY_W-1:0]  l_key;
    logic [COST_W-1:0] l_cost;
    logic              l_valid;
    logic              l_lt;
    logic              l_pre;
    logic [KEY_W-1:0]  r_key;
    logic [COST_W-1:0] r_cost;
    logic              r_valid;
    logic              r_lt;

    if (j == 0) begin : g_head
      // head sees an always-occupied, always-lower neighbor
      assign l_key   = '0;
      assign l_cost  = '0;
      assign l_valid = 1'b1;
      assign l_lt    = 1'b1;
      assign l_pre   = 1'b0;
    end else begin : g_left
      assign l_key   = cell_key[j-1];
      assign l_cost  = cell_cost[j-1];
      assign l_valid = valid_vec[j-1];
      assign l_lt    = lt_vec[j-1];
      assign l_pre   = pre_vec[j-1];
    end

    if (j == CAPACITY - 1) begin : g_tail
      assign r_key   = '0;
      assign r_cost  = '0;
      assign r_valid = 1'b0;
      assign r_lt    = 1'b0;
    end else begin : g_right
      assign r_key   = cell_key[j+1];
      assign r_cost  = cell_cost[j+1];
      assign r_valid = valid_vec[j+1];
      assign r_lt    = lt_vec[j+1];
    end

    assign last_vec[j] = valid_vec[j] && !r_valid;

    kdpq_cell #(
      .IW    (IW),
      .INDEX (j)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .rem_pos     (rem_pos),
      .in_key      (key_q),
      .in_cost     (cost_q),
      .left_key    (l_key),
      .left_cost   (l_cost),
      .left_valid  (l_valid),
      .left_lt     (l_lt),
      .left_pre    (l_pre),
      .right_key   (r_key),
      .right_cost  (r_cost),
      .right_valid (r_valid),
      .right_lt    (r_lt),
      .key         (cell_key[j]),
      .cost        (cell_cost[j]),
      .valid       (valid_vec[j]),
      .lt          (lt_vec[j]),
      .match       (match_vec[j]),
      .pre         (pre_vec[j])
    );
  end

  // ---- gather over the chain ----
  assign found    = |match_vec;
  assign found_lt = |(match_vec & lt_vec);
  assign sel_vec  = (act_q == ACT_DROP) ? last_vec : match_vec;

  always_comb begin
    match_pos = '0;
    sel_key   = '0;
    sel_cost  = '0;
    highest   = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (match_vec[j]) begin
        match_pos = match_pos | IW'(j);
      end
      if (sel_vec[j]) begin
        sel_key  = sel_key | cell_key[j];
        sel_cost = sel_cost | cell_cost[j];
      end
      if (last_vec[j]) begin
        highest = highest | cell_cost[j];
      end
    end
  end

  // ---- shift-step decision ----
  always_comb begin
    cmd             = '0;
    cmd.cmp         = (state == ST_CMP);
    cmd.shf         = (state == ST_SHF);
    rem_pos         = match_pos;
    count_next      = count;
    res_status_next = STAT_OK;
    res_key_next    = '0;
    res_cost_next   = '0;
    case (act_q)
      ACT_INSERT: begin
        if (found || (count != CW'(CAPACITY))) begin
          cmd.ins    = 1'b1;
          cmd.m_lt   = found_lt;
          cmd.pre_en = found;
          cmd.vin    = !found;
          if (!found) begin
            count_next = count + CW'(1);
          end
          res_key_next  = key_q;
          res_cost_next = cost_q;
        end else begin
          res_status_next = STAT_FULL;
        end
      end
      ACT_FIND: begin
        if (found) begin
          res_key_next  = sel_key;
          res_cost_next = sel_cost;
        end else begin
          res_status_next = STAT_NOTFOUND;
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          cmd.rem       = 1'b1;
          cmd.pre_en    = 1'b1;
          cmd.vout      = 1'b1;
          count_next    = count - CW'(1);
          res_key_next  = sel_key;
          res_cost_next = sel_cost;
        end else begin
          res_status_next = STAT_NOTFOUND;
        end
      end
      ACT_POP: begin
        if (count != '0) begin
          cmd.rem       = 1'b1;
          cmd.pre_en    = 1'b1;
          cmd.vout      = 1'b1;
          rem_pos       = '0;
          count_next    = count - CW'(1);
          res_key_next  = cell_key[0];
          res_cost_next = cell_cost[0];
        end else begin
          res_status_next = STAT_EMPTY;
        end
      end
      ACT_DROP: begin
        // top entry leaves; nothing below it moves
        if (count != '0) begin
          cmd.vout      = 1'b1;
          count_next    = count - CW'(1);
          res_key_next  = sel_key;
          res_cost_next = sel_cost;
        end else begin
          res_status_next = STAT_EMPTY;
        end
      end
      default: ;
    endcase
    if (state != ST_SHF) begin
      cmd.ins  = 1'b0;
      cmd.rem  = 1'b0;
      cmd.vin  = 1'b0;
      cmd.vout = 1'b0;
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP:  state_next = ST_SHF;
      ST_SHF:  state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SHF) begin
        count <= count_next;
      end
      if ((state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= s_tdata[2:0];
      key_q  <= s_tdata[34:3];
      cost_q <= s_tdata[50:35];
    end
    if (state == ST_SHF) begin
      res_status <= res_status_next;
      res_key    <= res_key_next;
      res_cost   <= res_cost_next;
    end
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= {7'd0, highest, COUNT_W'(count), res_cost, res_key, res_status};
    end
  end

  // ---- checks ----
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == count)
    else $error("occupied cells disagree with entry count");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHF) |-> $onehot0(match_vec))
    else $error("key stored in more than one cell");

  a_chain_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHF) |->
      ((lt_vec & (lt_vec + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0))
    else $error("less-than flags are not a prefix; chain out of order");

  a_accept_starts_compare: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CMP))
    else $error("accepted word did not start a compare step");

endmodule

/* test/open_list_checker.sv */
// Checker for the keyed priority queue: shadows the sorted store, predicts and compares words.
module open_list_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // action[2:0], key[34:3], cost[50:35], zero fill
  input  logic [kdpq_pkg::IN_W-1:0]   s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], out_key[33:2], out_cost[49:34], count[56:50], highest_cost[72:57], zero fill
  input  logic [kdpq_pkg::OUT_W-1:0]  m_tdata,
  output int                          mismatches,
  output int                          waiting
);
  import kdpq_pkg::*;

  localparam int KEY_LSB  = ACT_W;
  localparam int COST_LSB = ACT_W + KEY_W;
  localparam int OKEY_LSB = STAT_W;
  localparam int OCST_LSB = STAT_W + KEY_W;
  localparam int CNT_LSB  = STAT_W + KEY_W + COST_W;
  localparam int TOP_LSB  = CNT_LSB + COUNT_W;
  localparam int FILL_LSB = TOP_LSB + COST_W;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   key;
    logic [COST_W-1:0]  cost;
    logic [COUNT_W-1:0] count;
    logic [COST_W-1:0]  top_cost;
  } answer_t;

  // shadow of the sorted chain: ascending cost, newest first among equal costs
  logic [KEY_W-1:0]  shadow_key  [CAPACITY];
  logic [COST_W-1:0] shadow_cost [CAPACITY];
  int                shadow_count;
  answer_t           answers[$];
  answer_t           want;
  int                out_no;

  function automatic int slot_of(input logic [KEY_W-1:0] k);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_key[i]  = shadow_key[i+1];
      shadow_cost[i] = shadow_cost[i+1];
    end
    shadow_count--;
  endfunction

  // goes in front of the first entry whose cost is not lower
  function automatic void place_entry(input logic [KEY_W-1:0] k, input logic [COST_W-1:0] c);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_cost[pos] < c) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_key[i]  = shadow_key[i-1];
      shadow_cost[i] = shadow_cost[i-1];
    end
    shadow_key[pos]  = k;
    shadow_cost[pos] = c;
    shadow_count++;
  endfunction

  function automatic answer_t apply_word(input logic [ACT_W-1:0] act,
                                         input logic [KEY_W-1:0] k,
                                         input logic [COST_W-1:0] c);
    answer_t a;
    int      pos;
    a = '0;
    case (act)
      ACT_INSERT: begin
        pos = slot_of(k);
        if (pos >= 0) close_gap(pos);
        if (pos < 0 && shadow_count >= CAPACITY) begin
          a.status = STAT_FULL;
        end else begin
          place_entry(k, c);
          a.key  = k;
          a.cost = c;
        end
      end
      ACT_FIND, ACT_REMOVE: begin
        pos = slot_of(k);
        if (pos < 0) begin
          a.status = STAT_NOTFOUND;
        end else begin
          a.key  = shadow_key[pos];
          a.cost = shadow_cost[pos];
          if (act == ACT_REMOVE) close_gap(pos);
        end
      end
      ACT_POP, ACT_DROP: begin
        if (shadow_count == 0) begin
          a.status = STAT_EMPTY;
        end else begin
          pos    = (act == ACT_POP) ? 0 : shadow_count - 1;
          a.key  = shadow_key[pos];
          a.cost = shadow_cost[pos];
          close_gap(pos);
        end
      end
      default: ;  // spare codes leave the store alone
    endcase
    a.count    = COUNT_W'(shadow_count);
    a.top_cost = (shadow_count > 0) ? shadow_cost[shadow_count-1] : '0;
    return a;
  endfunction

  task automatic flag(input string what, input logic [KEY_W-1:0] exp_v,
                      input logic [KEY_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 40)
      $display("result word %0d, %s: expected %0h, got %0h", out_no, what, exp_v, got_v);
  endtask

  initial begin
    mismatches = 0;
    waiting    = 0;
    out_no     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      answers.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (answers.size() == 0) begin
          flag("word with nothing expected", '0, m_tdata[OKEY_LSB +: KEY_W]);
        end else begin
          want = answers.pop_front();
          if (m_tdata[STAT_W-1:0] !== want.status)
            flag("status", KEY_W'(want.status), KEY_W'(m_tdata[STAT_W-1:0]));
          if (m_tdata[OKEY_LSB +: KEY_W] !== want.key)
            flag("key", want.key, m_tdata[OKEY_LSB +: KEY_W]);
          if (m_tdata[OCST_LSB +: COST_W] !== want.cost)
            flag("cost", KEY_W'(want.cost), KEY_W'(m_tdata[OCST_LSB +: COST_W]));
          if (m_tdata[CNT_LSB +: COUNT_W] !== want.count)
            flag("count", KEY_W'(want.count), KEY_W'(m_tdata[CNT_LSB +: COUNT_W]));
          if (m_tdata[TOP_LSB +: COST_W] !== want.top_cost)
            flag("highest cost", KEY_W'(want.top_cost), KEY_W'(m_tdata[TOP_LSB +: COST_W]));
          if (m_tdata[OUT_W-1:FILL_LSB] !== '0)
            flag("fill bits", '0, KEY_W'(m_tdata[OUT_W-1:FILL_LSB]));
        end
        out_no++;
      end
      if (s_tvalid && s_tready)
        answers.push_back(apply_word(s_tdata[ACT_W-1:0], s_tdata[KEY_LSB +: KEY_W],
                                     s_tdata[COST_LSB +: COST_W]));
    end
    waiting = answers.size();
  end

endmodule

/* test/tb_keyed_double_ended_priority_queue.sv */
// Testbench top for the keyed priority queue: clock, reset, stimulus, back-pressure and verdict.
module tb_keyed_double_ended_priority_queue;
  import kdpq_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_SIZE    = 24;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  int mismatches;
  int waiting;
  int idle_pct;
  int stall_pct;
  int holds_asked;
  int quiet;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  keyed_double_ended_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  open_list_checker #(.CAPACITY(CAPACITY)) watch (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    m_tready     = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ends the run if no word moves on either side for too long
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // s_tvalid stays high from one word to the next unless an idle gap is drawn
  task automatic send(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                      input logic [COST_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({c, k, act});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(9);
    if (r < 3) return COST_W'($urandom_range(7));  // narrow range: many ties
    if (r == 3) return $urandom_range(1) ? '1 : '0;
    return COST_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(4) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  task automatic random_mix(input int n);
    int               r;
    logic [ACT_W-1:0] act;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 40)      act = ACT_INSERT;
      else if (r < 55) act = ACT_FIND;
      else if (r < 70) act = ACT_REMOVE;
      else if (r < 82) act = ACT_POP;
      else if (r < 94) act = ACT_DROP;
      else             act = ACT_W'($urandom_range(int'(ACT_DROP) + 1, (1 << ACT_W) - 1));
      send(act, pick_key(), pick_cost());
    end
  endtask

  // fill past capacity with fresh keys, hit the full store, then empty it
  task automatic fill_and_drain();
    logic [KEY_W-1:0] first_key;
    first_key = $urandom;
    send(ACT_INSERT, first_key, pick_cost());
    repeat (CAPACITY + 5) send(ACT_INSERT, $urandom, pick_cost());
    send(ACT_INSERT, first_key, pick_cost());  // present key while full: replaced
    repeat (8) send(ACT_INSERT, pick_key(), pick_cost());
    send(ACT_FIND, first_key, '0);
    repeat (CAPACITY + 4) send($urandom_range(1) ? ACT_POP : ACT_DROP, pick_key(), pick_cost());
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    holds_asked = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty store, ties at both ends, replacement, misses, spare codes
    send(ACT_POP, '0, '0);
    send(ACT_DROP, '1, '1);
    send(ACT_FIND, '0, '0);
    send(ACT_REMOVE, '1, '0);
    send(ACT_INSERT, '0, '0);
    send(ACT_INSERT, '1, '1);
    send(ACT_INSERT, 32'h1234_5678, '0);
    send(ACT_INSERT, 32'hA5A5_A5A5, '1);
    send(ACT_FIND, '1, '0);
    send(ACT_FIND, 32'hDEAD_BEEF, 16'h5555);
    send(ACT_REMOVE, 32'hDEAD_BEEF, '0);
    send(ACT_INSERT, '0, 16'h8000);
    send(ACT_REMOVE, 32'h1234_5678, '0);
    for (int a = int'(ACT_DROP) + 1; a < (1 << ACT_W); a++)
      send(ACT_W'(a), 32'h5A5A_5A5A, 16'hC3C3);
    send(ACT_DROP, '0, '0);
    send(ACT_POP, '0, '0);
    send(ACT_POP, '0, '0);
    send(ACT_POP, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      fill_and_drain();
      random_mix(150);
    end

    // receiver holds off while words keep coming: input must stall
    idle_pct  = 0;
    stall_pct = 0;
    holds_asked++;
    random_mix(100);

    s_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
